/* sv/bchq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchq_pkg
// Shared types and constants of the Bayer channel histogram / quantile unit.
// ----------------------------------------------------------------------------
package bchq_pkg;

  localparam int unsigned BinCount  = 256;
  localparam int unsigned BinW      = 8;
  localparam int unsigned CountBits = 24;
  localparam int unsigned PosW      = 12;
  localparam int unsigned DimW      = 13;
  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned PixW      = 10;
  localparam int unsigned QW        = 17;
  localparam int unsigned QOne      = 65536;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned OpW       = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ChanW     = 2;
  localparam int unsigned ChanCount = 3;

  // operation codes
  localparam logic [OpW-1:0] OP_ADD   = 2'd0;
  localparam logic [OpW-1:0] OP_CLEAR = 2'd1;
  localparam logic [OpW-1:0] OP_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PATTERN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT  = 2'd2;

  // mosaic orders
  localparam logic [1:0] PAT_RGGB = 2'd0;
  localparam logic [1:0] PAT_BGGR = 2'd1;
  localparam logic [1:0] PAT_GBRG = 2'd2;
  localparam logic [1:0] PAT_GRBG = 2'd3;

  // color channels, also the upper address bits of the bin memory
  localparam logic [ChanW-1:0] CH_RED   = 2'd0;
  localparam logic [ChanW-1:0] CH_GREEN = 2'd1;
  localparam logic [ChanW-1:0] CH_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_BUMP,
    CMD_CLEAR,
    CMD_QUERY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [ChanW-1:0] chan;
    logic [BinW-1:0]  bin;
    logic [QW-1:0]    q;
  } cmd_t;

endpackage
`default_nettype wire

/* sv/bchq_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchq_in_if
// Input item channel: operation, pixel sample, frame start, quantile level.
// ----------------------------------------------------------------------------
interface bchq_in_if;
  logic                         valid;
  logic                         ready;
  logic [bchq_pkg::OpW-1:0]     operation;
  logic [bchq_pkg::PixW-1:0]    pixel_value;
  logic                         frame_start;
  logic [bchq_pkg::QW-1:0]      quantile_level;

  modport source (output valid, operation, pixel_value, frame_start, quantile_level,
                  input ready);
  modport sink   (input valid, operation, pixel_value, frame_start, quantile_level,
                  output ready);
endinterface
`default_nettype wire

/* sv/bchq_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchq_out_if
// Result item channel: per-color quantile bin levels.
// ----------------------------------------------------------------------------
interface bchq_out_if;
  logic                        valid;
  logic                        ready;
  logic [bchq_pkg::LevelW-1:0] red_level;
  logic [bchq_pkg::LevelW-1:0] green_level;
  logic [bchq_pkg::LevelW-1:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface
`default_nettype wire

/* sv/bchq_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchq_front
// Accepts items, tracks raster position and classifies each into a command.
// ----------------------------------------------------------------------------
module bchq_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  bchq_in_if.sink                            in_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bchq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bchq_pkg::DimW-1:0]     cfg_wdata_i,
  input  wire logic                          init_done_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output bchq_pkg::cmd_t                     cmd_o
);

  localparam int unsigned PosW = bchq_pkg::PosW;
  localparam int unsigned DimW = bchq_pkg::DimW;

  logic [1:0]      pattern_q;
  logic [DimW-1:0] width_q, height_q;
  logic [PosW-1:0] col_q, row_q;

  logic [DimW-1:0] w_cl, h_cl, w_even, h_even;
  logic [PosW-1:0] col_cur, row_cur, col_inc, row_inc, col_nxt, row_nxt;
  logic            col_wrap, in_area, accept;
  logic            rp, cp, green_even, is_green, red_row;
  logic [bchq_pkg::ChanW-1:0] chan;

  always_comb begin
    w_cl = width_q;
    if (width_q == '0) w_cl = DimW'(1);
    else if (width_q > DimW'(bchq_pkg::MaxDim)) w_cl = DimW'(bchq_pkg::MaxDim);
    h_cl = height_q;
    if (height_q == '0) h_cl = DimW'(1);
    else if (height_q > DimW'(bchq_pkg::MaxDim)) h_cl = DimW'(bchq_pkg::MaxDim);
  end

  assign w_even = {w_cl[DimW-1:1], 1'b0};
  assign h_even = {h_cl[DimW-1:1], 1'b0};

  assign col_cur = in_i.frame_start ? '0 : col_q;
  assign row_cur = in_i.frame_start ? '0 : row_q;
  assign in_area = ({1'b0, col_cur} < w_even) && ({1'b0, row_cur} < h_even);

  assign col_inc  = col_cur + PosW'(1);
  assign col_wrap = ({1'b0, col_inc} >= w_cl) || (col_inc == '0);
  assign row_inc  = row_cur + PosW'(1);

  always_comb begin
    col_nxt = col_inc;
    row_nxt = row_cur;
    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = ({1'b0, row_inc} >= h_cl) ? '0 : row_inc;
    end
  end

  // color of the site
  assign rp         = row_cur[0];
  assign cp         = col_cur[0];
  assign green_even = (pattern_q == bchq_pkg::PAT_GBRG) || (pattern_q == bchq_pkg::PAT_GRBG);
  assign is_green   = green_even ? ((rp ^ cp) == 1'b0) : ((rp ^ cp) == 1'b1);
  assign red_row    = (pattern_q == bchq_pkg::PAT_BGGR) || (pattern_q == bchq_pkg::PAT_GBRG);

  always_comb begin
    if (is_green) chan = bchq_pkg::CH_GREEN;
    else if (rp == red_row) chan = bchq_pkg::CH_RED;
    else chan = bchq_pkg::CH_BLUE;
  end

  assign in_i.ready = init_done_i && !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    cmd_o.kind = bchq_pkg::CMD_BUMP;
    cmd_o.chan = chan;
    cmd_o.bin  = in_i.pixel_value[bchq_pkg::PixW-1 -: bchq_pkg::BinW];
    cmd_o.q    = (in_i.quantile_level > bchq_pkg::QW'(bchq_pkg::QOne)) ?
                 bchq_pkg::QW'(bchq_pkg::QOne) : in_i.quantile_level;
    push_o     = 1'b0;
    unique case (in_i.operation)
      bchq_pkg::OP_ADD: begin
        push_o = accept && in_area;
      end
      bchq_pkg::OP_CLEAR: begin
        cmd_o.kind = bchq_pkg::CMD_CLEAR;
        push_o     = accept;
      end
      bchq_pkg::OP_QUERY: begin
        cmd_o.kind = bchq_pkg::CMD_QUERY;
        push_o     = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= bchq_pkg::PAT_RGGB;
      width_q   <= DimW'(1920);
      height_q  <= DimW'(1080);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bchq_pkg::CFG_PATTERN: pattern_q <= cfg_wdata_i[1:0];
        bchq_pkg::CFG_WIDTH:   width_q   <= cfg_wdata_i;
        bchq_pkg::CFG_HEIGHT:  height_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // raster position, advanced by every accepted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept && (in_i.operation == bchq_pkg::OP_ADD)) begin
      col_q <= col_nxt;
      row_q <= row_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/bchq_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchq_queue
// Short command queue between the classifier and the histogram engine.
// ----------------------------------------------------------------------------
module bchq_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bchq_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output bchq_pkg::cmd_t      cmd_o,
  output logic                empty_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  bchq_pkg::cmd_t  slot_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i)  rd_q <= rd_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule
`default_nettype wire

/* sv/bchq_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchq_back
// Histogram engine: bin memory, bump pipeline, clear sweep, quantile search.
// ----------------------------------------------------------------------------
module bchq_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire bchq_pkg::cmd_t cmd_i,
  output logic                pop_o,
  output logic                init_done_o,
  bchq_out_if.source          out_o
);

  localparam int unsigned BinW      = bchq_pkg::BinW;
  localparam int unsigned CountBits = bchq_pkg::CountBits;
  localparam int unsigned ChanW     = bchq_pkg::ChanW;
  localparam int unsigned MemDepth  = bchq_pkg::ChanCount * bchq_pkg::BinCount;
  localparam int unsigned AddrW     = ChanW + BinW;
  localparam int unsigned PtrW      = BinW + 1;
  localparam int unsigned TotW      = CountBits + BinW;
  localparam int unsigned FracW     = bchq_pkg::QW - 1;
  localparam int unsigned ThrW      = TotW + bchq_pkg::QW;
  localparam logic [CountBits-1:0] CountMax = '1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;

  logic [CountBits-1:0] bin_mem [MemDepth];
  logic [CountBits-1:0] rdata_q;

  logic [2:0]            state_q;
  logic [ChanW-1:0]      chan_q;
  logic [PtrW-1:0]       ptr_q;
  logic                  init_done_q, out_valid_q;
  logic                  b_valid_q, hit_q, rd_sum_q, rd_scan_q;
  logic [AddrW-1:0]      b_addr_q;
  logic [CountBits-1:0]  fwd_q;
  logic [TotW-1:0]       total_q, cum_q;
  logic [ThrW-1:0]       thr_q;
  logic [bchq_pkg::QW-1:0] q_q;
  logic [BinW-1:0]       rd_bin_q;
  logic [bchq_pkg::LevelW-1:0] red_q, green_q, blue_q;

  logic                  pop, pop_bump, issue, hit, mem_we;
  logic [AddrW-1:0]      mem_raddr, mem_waddr, head_addr;
  logic [CountBits-1:0]  mem_wdata, old_cnt, bumped;
  logic [TotW-1:0]       cum_d;

  assign head_addr = {cmd_i.chan, cmd_i.bin};

  always_comb begin
    pop = 1'b0;
    if ((state_q == ST_IDLE) && !q_empty_i) begin
      unique case (cmd_i.kind)
        bchq_pkg::CMD_BUMP:  pop = 1'b1;
        bchq_pkg::CMD_CLEAR: pop = 1'b1;
        bchq_pkg::CMD_QUERY: pop = !out_valid_q;
        default:             pop = 1'b1;
      endcase
    end
  end

  assign pop_o    = pop;
  assign pop_bump = pop && (cmd_i.kind == bchq_pkg::CMD_BUMP);

  // bump stage: read data arrives, a write to the same bin made at the edge
  // that captured it is not yet visible in it
  assign old_cnt = hit_q ? fwd_q : rdata_q;
  assign bumped  = (old_cnt == CountMax) ? old_cnt : old_cnt + CountBits'(1);

  // quantile search
  assign cum_d = cum_q + TotW'(rdata_q);
  assign hit   = rd_scan_q && ({1'b0, cum_d, FracW'(0)} >= thr_q);
  assign issue = ((state_q == ST_SUM) || ((state_q == ST_SCAN) && !hit)) && !ptr_q[BinW];

  assign mem_raddr = ((state_q == ST_SUM) || (state_q == ST_SCAN)) ?
                     {chan_q, ptr_q[BinW-1:0]} : head_addr;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = {chan_q, ptr_q[BinW-1:0]};
      mem_wdata = '0;
    end else begin
      mem_we    = b_valid_q;
      mem_waddr = b_addr_q;
      mem_wdata = bumped;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
    rdata_q <= bin_mem[mem_raddr];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      chan_q      <= bchq_pkg::CH_RED;
      ptr_q       <= '0;
      init_done_q <= 1'b0;
      out_valid_q <= 1'b0;
      b_valid_q   <= 1'b0;
      hit_q       <= 1'b0;
      rd_sum_q    <= 1'b0;
      rd_scan_q   <= 1'b0;
    end else begin
      b_valid_q <= pop_bump;
      hit_q     <= pop_bump && b_valid_q && (head_addr == b_addr_q);
      rd_sum_q  <= issue && (state_q == ST_SUM);
      rd_scan_q <= issue && (state_q == ST_SCAN);
      if (out_o.valid && out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (pop && (cmd_i.kind == bchq_pkg::CMD_CLEAR)) begin
            state_q <= ST_CLEAR;
            chan_q  <= bchq_pkg::CH_RED;
            ptr_q   <= '0;
          end else if (pop && (cmd_i.kind == bchq_pkg::CMD_QUERY)) begin
            state_q <= ST_SUM;
            chan_q  <= bchq_pkg::CH_RED;
            ptr_q   <= '0;
          end
        end
        ST_CLEAR: begin
          if (ptr_q[BinW-1:0] == '1) begin
            ptr_q <= '0;
            if (chan_q == bchq_pkg::CH_BLUE) begin
              state_q     <= ST_IDLE;
              init_done_q <= 1'b1;
            end else begin
              chan_q <= chan_q + ChanW'(1);
            end
          end else begin
            ptr_q <= ptr_q + PtrW'(1);
          end
        end
        ST_SUM: begin
          if (!ptr_q[BinW]) ptr_q <= ptr_q + PtrW'(1);
          else state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_SCAN;
          ptr_q   <= '0;
        end
        ST_SCAN: begin
          if (hit) begin
            ptr_q <= '0;
            if (chan_q == bchq_pkg::CH_BLUE) begin
              state_q     <= ST_IDLE;
              out_valid_q <= 1'b1;
            end else begin
              chan_q  <= chan_q + ChanW'(1);
              state_q <= ST_SUM;
            end
          end else if (!ptr_q[BinW]) begin
            ptr_q <= ptr_q + PtrW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    b_addr_q <= head_addr;
    fwd_q    <= bumped;
    rd_bin_q <= ptr_q[BinW-1:0];
    if (pop) q_q <= cmd_i.q;
    if (rd_sum_q) total_q <= total_q + TotW'(rdata_q);
    if (state_q == ST_MUL) begin
      thr_q <= ThrW'(total_q) * ThrW'(q_q);
      cum_q <= '0;
    end
    if (rd_scan_q) cum_q <= cum_d;
    if ((state_q == ST_IDLE) || hit) total_q <= '0;
    if (hit) begin
      case (chan_q)
        bchq_pkg::CH_RED:   red_q   <= rd_bin_q;
        bchq_pkg::CH_GREEN: green_q <= rd_bin_q;
        default:            blue_q  <= rd_bin_q;
      endcase
    end
  end

  assign init_done_o       = init_done_q;
  assign out_o.valid       = out_valid_q;
  assign out_o.red_level   = red_q;
  assign out_o.green_level = green_q;
  assign out_o.blue_level  = blue_q;

endmodule
`default_nettype wire

/* sv/bayer_channel_histogram_quantile_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bayer_channel_histogram_quantile_unit
// Per-color 256-bin histograms of raw Bayer pixels with quantile level query.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    operation, pixel_value, frame_start,
//                                quantile_level
//  out_o     out  valid/ready    red_level, green_level, blue_level
//  cfg_*     in   cfg_we_i       cfg_idx_i, cfg_wdata_i (write only)
//
//  Pixels: one per cycle while the command queue has room; each becomes a
//  read-modify-write of its bin in the single-port-write bin memory, two
//  stages deep, with forwarding. Clear: one memory word per cycle. Query:
//  per color a sum pass, a multiply step and a search pass that may end early.
//  After reset the same clearing pass runs; in_i.ready stays low.
//  A 4-entry command queue lets the input side keep taking items while the
//  engine sweeps or while a result waits on out_o.ready.
// ----------------------------------------------------------------------------
module bayer_channel_histogram_quantile_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  bchq_in_if.sink                           in_i,
  bchq_out_if.source                        out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [bchq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [bchq_pkg::DimW-1:0]    cfg_wdata_i
);

  // classifier -> queue
  logic           push, q_full;
  bchq_pkg::cmd_t push_cmd;

  // queue -> engine
  logic           pop, q_empty;
  bchq_pkg::cmd_t head_cmd;

  // engine finished its post-reset clearing pass
  logic           init_done;

  // Front: config registers, raster position, color classification.
  // Unbinned pixels (odd trailing column/row) and unused operations are
  // dropped here and never reach the queue.
  bchq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  bchq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty)
  );

  // Back: bin memory addressed {color, bin}; bumps, clear sweep and the
  // quantile search with the result register on out_o.
  bchq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

/* test/bchq_quantile_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchq_quantile_checker
// Watches the item and result channels and the register port. It keeps its
// own copy of the three color histograms and the frame position, and works
// out the levels each query should return. Results are compared in order.
// ----------------------------------------------------------------------------
module bchq_quantile_checker
  import bchq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  bchq_in_if                      items_i,
  bchq_out_if                     levels_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DimW-1:0]    cfg_wdata_i,
  output int unsigned             fail_count_o,
  output int unsigned             results_due_o
);

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } levels_t;

  localparam longint unsigned CountMax = (64'd1 << CountBits) - 64'd1;

  int unsigned     counts [ChanCount][BinCount];
  logic [1:0]      pattern;
  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;
  logic [PosW-1:0] col;
  logic [PosW-1:0] row;
  levels_t         levels_due [$];

  task automatic report(string msg);
    fail_count_o++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  function automatic void clear_counts();
    for (int c = 0; c < ChanCount; c++) begin
      for (int b = 0; b < BinCount; b++) counts[c][b] = 0;
    end
  endfunction

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  // place one pixel, then advance the raster position
  function automatic void add_pixel(logic [PixW-1:0] pix, logic frame_start);
    int unsigned      w;
    int unsigned      h;
    logic             rp;
    logic             cp;
    logic             is_green;
    logic             red_row;
    logic [ChanW-1:0] chan;
    logic [BinW-1:0]  bin_idx;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    bin_idx = pix[PixW-1:2];
    if (frame_start) begin
      col = '0;
      row = '0;
    end
    // trailing odd column / row is skipped
    if (col < (w & ~32'd1) && row < (h & ~32'd1)) begin
      rp = row[0];
      cp = col[0];
      if (pattern == PAT_GBRG || pattern == PAT_GRBG) is_green = ~(rp ^ cp);
      else is_green = rp ^ cp;
      red_row = (pattern == PAT_BGGR || pattern == PAT_GBRG);
      if (is_green) chan = CH_GREEN;
      else if (rp == red_row) chan = CH_RED;
      else chan = CH_BLUE;
      if (counts[chan][bin_idx] < CountMax) counts[chan][bin_idx]++;
    end
    col = col + 1'b1;
    if (col >= w || col == '0) begin
      col = '0;
      row = row + 1'b1;
      if (row >= h) row = '0;
    end
  endfunction

  // first bin whose running count times one reaches total times q
  function automatic logic [LevelW-1:0] first_bin_reaching(logic [ChanW-1:0] chan,
                                                           longint unsigned q);
    longint unsigned total;
    longint unsigned cum;
    longint unsigned thr;
    total = 0;
    cum = 0;
    for (int b = 0; b < BinCount; b++) total += counts[chan][b];
    thr = total * q;
    for (int b = 0; b < BinCount; b++) begin
      cum += counts[chan][b];
      if (cum * QOne >= thr) return b[LevelW-1:0];
    end
    return LevelW'(BinCount - 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    levels_t         got;
    levels_t         want;
    longint unsigned q;
    if (!rst_ni) begin
      pattern    = PAT_RGGB;
      width_reg  = 13'd1920;
      height_reg = 13'd1080;
      col = '0;
      row = '0;
      clear_counts();
      levels_due.delete();
    end else begin
      // a result can never belong to an item taken at the same edge
      if (levels_i.valid && levels_i.ready) begin
        got = {levels_i.red_level, levels_i.green_level, levels_i.blue_level};
        if (levels_due.size() == 0) begin
          report($sformatf("result %0d/%0d/%0d with no query pending",
                           got.red, got.green, got.blue));
        end else begin
          want = levels_due.pop_front();
          if (got.red != want.red)
            report($sformatf("red_level %0d, expected %0d", got.red, want.red));
          if (got.green != want.green)
            report($sformatf("green_level %0d, expected %0d", got.green, want.green));
          if (got.blue != want.blue)
            report($sformatf("blue_level %0d, expected %0d", got.blue, want.blue));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN: pattern    = cfg_wdata_i[1:0];
          CFG_WIDTH:   width_reg  = cfg_wdata_i;
          CFG_HEIGHT:  height_reg = cfg_wdata_i;
          default: ;
        endcase
      end
      if (items_i.valid && items_i.ready) begin
        case (items_i.operation)
          OP_ADD:   add_pixel(items_i.pixel_value, items_i.frame_start);
          OP_CLEAR: clear_counts();
          OP_QUERY: begin
            q = items_i.quantile_level;
            if (q > QOne) q = QOne;
            want.red   = first_bin_reaching(CH_RED, q);
            want.green = first_bin_reaching(CH_GREEN, q);
            want.blue  = first_bin_reaching(CH_BLUE, q);
            levels_due.push_back(want);
          end
          default: ;
        endcase
      end
    end
    results_due_o = levels_due.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the Bayer histogram / quantile unit: a short directed run at the
// reset register values, then phases of random items, each under its own
// mosaic order and frame size. A checker beside the unit predicts every
// query result; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import bchq_pkg::*;

  // codes the package leaves unnamed: the spare operation and register slot
  localparam logic [OpW-1:0]     OpUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  localparam logic [QW-1:0] QFull = QW'(QOne);

  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned RandomItems  = 1030;
  // Receiver hold-off: longer than one query sweep, so the finished result holds
  // back the next query and the 4-entry queue backs up.
  localparam int unsigned LongHold     = 2500;
  // Slowest legal quiet stretch: clearing pass after reset, a held result plus
  // a query sweep behind it. The limit is several times that.
  localparam int unsigned StallLimit   = 20000;
  // Every phase ends on a query, so once its result is in, nothing is in
  // flight; SettleCycles adds margin before register writes.
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned TailCycles   = 100;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DimW-1:0]    cfg_wdata;
  logic               hold_req;   // asks the receiver for its one long hold-off
  logic               quiet;      // phase runs with no idling on either side
  int unsigned        fail_count;
  int unsigned        results_due;
  int unsigned        stall_cycles;

  bchq_in_if  in_ch ();
  bchq_out_if out_ch ();

  bayer_channel_histogram_quantile_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bchq_quantile_checker levels_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .items_i       (in_ch),
    .levels_i      (out_ch),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: any cycle without an accepted item or result counts toward the
  // limit; reaching it means the unit has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("[%0t] timeout: nothing moved for %0d cycles", $time, StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Quantile mix: zero, exactly one, anywhere up to one, and anywhere in the
  // full 17-bit range, above one included, so every bit toggles.
  function automatic logic [QW-1:0] pick_quantile();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return QFull;
    if (r < 80) return QW'($urandom_range(0, QOne));
    return QW'($urandom_range(0, (1 << QW) - 1));
  endfunction

  // Offer one item from a falling edge, hold it until taken, then maybe idle.
  // valid is left high when no gap follows, so back-to-back items never see
  // valid dropped and raised in one time step.
  task automatic push_item(logic [OpW-1:0] op, logic [PixW-1:0] pix, logic frame_start,
                           logic [QW-1:0] q);
    int unsigned gap;
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.pixel_value    <= pix;
    in_ch.frame_start    <= frame_start;
    in_ch.quantile_level <= q;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Result side: runs of ready with random stalls, plus the one long hold-off
  // that fills the unit up and makes it refuse input.
  initial begin
    int unsigned gap;
    logic        hold_done;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Item side and verdict
  initial begin
    logic [1:0]      pat;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic [OpW-1:0]  op;
    logic            frame_start;
    int unsigned     r;
    int unsigned     n;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_PATTERN;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = OP_ADD;
    in_ch.pixel_value    = '0;
    in_ch.frame_start    = 1'b0;
    in_ch.quantile_level = '0;
    hold_req             = 1'b0;
    quiet                = 1'b0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, at reset values (RGGB, 1920 x 1080): row 0 holds red and
    // green sites only. The unit runs its clearing pass first; push_item
    // simply waits for ready.
    push_item(OP_QUERY, '0, 1'b0, QFull);          // empty histograms answer bin 0
    push_item(OP_QUERY, '1, 1'b1, '0);             // zero fraction; frame start ignored
    push_item(OP_ADD, '1, 1'b1, '1);               // top code at origin: red, last bin
    push_item(OP_ADD, '0, 1'b0, '0);               // green, bin 0
    push_item(OP_ADD, 10'd3, 1'b0, '0);            // red, low bits dropped
    push_item(OP_ADD, 10'd4, 1'b0, '0);            // green, bin 1
    push_item(OP_ADD, 10'd512, 1'b0, '0);          // red, bin 128
    push_item(OP_QUERY, '0, 1'b0, QFull);
    push_item(OP_QUERY, '0, 1'b0, 17'd1);          // smallest nonzero fraction
    push_item(OP_QUERY, '0, 1'b0, 17'd32768);      // median
    push_item(OP_QUERY, '0, 1'b0, '1);             // far above one, treated as one
    push_item(OpUnused, '1, 1'b1, '1);             // spare operation: no effect
    push_item(OP_CLEAR, '1, 1'b1, '1);             // clear keeps the position
    push_item(OP_QUERY, '0, 1'b0, 17'd49152);
    push_item(OP_ADD, '1, 1'b1, '0);
    push_item(OP_ADD, '1, 1'b0, '0);
    push_item(OP_QUERY, '0, 1'b1, QFull + 1'b1);   // just above one
    drain_results();

    // Random phases. Small frames make the position wrap often and hit odd
    // trailing columns/rows; a few phases use the clamped extremes. No frame
    // start is forced at a phase change, so a position left beyond a smaller
    // frame has to wrap.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin pat = PAT_RGGB; w = 13'd4;  h = 13'd4;  end
        1: begin pat = PAT_BGGR; w = 13'd5;  h = 13'd3;  end
        2: begin pat = PAT_GBRG; w = 13'd1;  h = 13'd1;  end  // nothing binned
        3: begin pat = PAT_GRBG; w = 13'd7;  h = 13'd6;  end
        4: begin pat = 2'($urandom); w = '0; h = '1; end      // clamp to 1 and max
        5: begin pat = 2'($urandom); w = '1; h = '0; end
        6: begin pat = 2'($urandom); w = DimW'(MaxDim); h = 13'd2; end
        7: begin pat = 2'($urandom); w = 13'd3; h = DimW'(MaxDim); end
        default: begin
          pat = 2'($urandom);
          w   = DimW'($urandom_range(1, 9));
          h   = DimW'($urandom_range(1, 9));
        end
      endcase

      // Register writes, back to back; upper pattern bits are junk the unit
      // must ignore, and the spare index must change nothing.
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_PATTERN;
      cfg_wdata <= {(DimW-2)'($urandom), pat};
      @(negedge clk);
      cfg_idx   <= CFG_WIDTH;
      cfg_wdata <= w;
      @(negedge clk);
      cfg_idx   <= CFG_HEIGHT;
      cfg_wdata <= h;
      @(negedge clk);
      cfg_idx   <= CfgUnused;
      cfg_wdata <= DimW'($urandom);
      @(negedge clk);
      cfg_we    <= 1'b0;

      quiet = ($urandom_range(0, 3) == 0);
      if (ph == 3) begin
        // back-pressure: a query whose result is held while pixels keep coming
        quiet    = 1'b0;
        hold_req = 1'b1;
        push_item(OP_QUERY, PixW'($urandom), 1'($urandom), pick_quantile());
      end

      n = 0;
      while (n < RandomItems / PhaseCount) begin
        r = $urandom_range(0, 99);
        if (r < 86) op = OP_ADD;
        else if (r < 95) op = OP_QUERY;
        else if (r < 98) op = OP_CLEAR;
        else op = OpUnused;
        frame_start = (op == OP_ADD) ? ($urandom_range(0, 24) == 0) : 1'($urandom);
        push_item(op, PixW'($urandom), frame_start, pick_quantile());
        if (op != OpUnused) n++;
      end
      // closing query: once it answers, all earlier work is done
      push_item(OP_QUERY, PixW'($urandom), 1'($urandom), pick_quantile());
      drain_results();
    end

    // catch any stray result after the last expected one
    repeat (TailCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/bchq_pkg.sv
sv/bchq_in_if.sv
sv/bchq_out_if.sv
sv/bchq_front.sv
sv/bchq_queue.sv
sv/bchq_back.sv
sv/bayer_channel_histogram_quantile_unit.sv
test/bchq_quantile_checker.sv
test/tb.sv
